// ----- hw/rtl/lbdp_pkg.sv -----
package lbdp_pkg;

	localparam int unsigned SAMPLE_W = 12;
	localparam int unsigned TIME_W   = 32;
	localparam int unsigned PULSE_W  = 16;
	localparam int unsigned MASK_W   = 4;
	localparam int unsigned BTN_W    = 3;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned IN_TDATA_W  = 48;
	localparam int unsigned OUT_TDATA_W = 8;

	typedef enum logic [BTN_W-1:0] {
		BTN_NONE   = 3'd0,
		BTN_MAIN   = 3'd1,
		BTN_CANCEL = 3'd2,
		BTN_RES    = 3'd3,
		BTN_SET    = 3'd4
	} btn_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LVL_MAIN        = 3'd0,
		REG_LVL_CANCEL      = 3'd1,
		REG_LVL_RESUME      = 3'd2,
		REG_OPEN_MIN        = 3'd3,
		REG_PULSE_MAIN_MS   = 3'd4,
		REG_PULSE_CANCEL_MS = 3'd5,
		REG_PULSE_RES_MS    = 3'd6,
		REG_PULSE_SET_MS    = 3'd7
	} reg_idx_t;

	localparam logic [SAMPLE_W-1:0] RST_LVL_MAIN   = 12'd500;
	localparam logic [SAMPLE_W-1:0] RST_LVL_CANCEL = 12'd1500;
	localparam logic [SAMPLE_W-1:0] RST_LVL_RESUME = 12'd2500;
	localparam logic [SAMPLE_W-1:0] RST_OPEN_MIN   = 12'd3500;
	localparam logic [PULSE_W-1:0]  RST_PULSE_MS   = 16'd200;

	typedef struct packed {
		logic [SAMPLE_W-1:0] lvl_main;
		logic [SAMPLE_W-1:0] lvl_cancel;
		logic [SAMPLE_W-1:0] lvl_resume;
		logic [SAMPLE_W-1:0] open_min;
		logic [3:0][PULSE_W-1:0] pulse_ms;
	} cfg_t;

	typedef struct packed {
		btn_t              cand;
		logic [TIME_W-1:0] cand_target;
		btn_t              stable;
		btn_t              driving;
		logic [TIME_W-1:0] deadline;
		logic [MASK_W-1:0] drive_bits;
	} state_t;

endpackage

// ----- hw/rtl/ladder_button_debounce_pulse.sv -----
// Channel  Direction  Payload (lowest bit first)
// s_axis   in         tdata: adc_sample[11:0], now_ms[43:12], zero fill [47:44]
// m_axis   out        tdata: output_mask[3:0], confirmed_button[6:4], zero fill [7]
// cfg      in         cfg_we, cfg_index (register number), cfg_data
//
// One transfer is taken per cycle while m_axis does not stall; each input is held in
// the s1 register and its result in the s2 register, which drives m_axis.
// The classify, debounce and hold-time logic is combinational between them.
// A stall on m_axis holds the result and the input register; s_tready drops only
// when both are full. Reset clears all button state and loads the default registers.
module ladder_button_debounce_pulse #(
	parameter int unsigned DEBOUNCE_TIME_MS = 50
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [lbdp_pkg::IN_TDATA_W-1:0]       s_tdata,   // adc_sample, now_ms
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [lbdp_pkg::OUT_TDATA_W-1:0]      m_tdata,   // output_mask, confirmed_button
	input  logic                                  cfg_we,
	input  logic [lbdp_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [lbdp_pkg::CFG_DATA_W-1:0]       cfg_data
);
	import lbdp_pkg::*;

	cfg_t   cfg_q;
	state_t state_q;
	state_t state_next;

	logic                valid_s1;
	logic [SAMPLE_W-1:0] sample_s1;
	logic [TIME_W-1:0]   now_s1;
	logic                valid_s2;
	logic [MASK_W-1:0]   mask_s2;
	btn_t                btn_s2;
	logic                advance;

	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lvl_main   <= RST_LVL_MAIN;
			cfg_q.lvl_cancel <= RST_LVL_CANCEL;
			cfg_q.lvl_resume <= RST_LVL_RESUME;
			cfg_q.open_min   <= RST_OPEN_MIN;
			cfg_q.pulse_ms   <= {4{RST_PULSE_MS}};
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_LVL_MAIN:        cfg_q.lvl_main    <= cfg_data[SAMPLE_W-1:0];
				REG_LVL_CANCEL:      cfg_q.lvl_cancel  <= cfg_data[SAMPLE_W-1:0];
				REG_LVL_RESUME:      cfg_q.lvl_resume  <= cfg_data[SAMPLE_W-1:0];
				REG_OPEN_MIN:        cfg_q.open_min    <= cfg_data[SAMPLE_W-1:0];
				REG_PULSE_MAIN_MS:   cfg_q.pulse_ms[0] <= cfg_data[PULSE_W-1:0];
				REG_PULSE_CANCEL_MS: cfg_q.pulse_ms[1] <= cfg_data[PULSE_W-1:0];
				REG_PULSE_RES_MS:    cfg_q.pulse_ms[2] <= cfg_data[PULSE_W-1:0];
				REG_PULSE_SET_MS:    cfg_q.pulse_ms[3] <= cfg_data[PULSE_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			sample_s1 <= s_tdata[SAMPLE_W-1:0];
			now_s1    <= s_tdata[SAMPLE_W+TIME_W-1:SAMPLE_W];
		end
	end

	lbdp_step #(
		.DEBOUNCE_TIME_MS(DEBOUNCE_TIME_MS)
	) u_step (
		.cfg       (cfg_q),
		.state     (state_q),
		.adc_sample(sample_s1),
		.now_ms    (now_s1),
		.state_next(state_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.cand        <= BTN_NONE;
			state_q.cand_target <= TIME_W'(DEBOUNCE_TIME_MS);
			state_q.stable      <= BTN_NONE;
			state_q.driving     <= BTN_NONE;
			state_q.deadline    <= '0;
			state_q.drive_bits  <= '0;
		end else if (advance) begin
			state_q <= state_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			mask_s2 <= state_next.drive_bits;
			btn_s2  <= state_next.stable;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {1'b0, btn_s2, mask_s2};

endmodule

// ----- hw/rtl/lbdp_step.sv -----
module lbdp_step #(
	parameter int unsigned DEBOUNCE_TIME_MS = 50
) (
	input  lbdp_pkg::cfg_t                       cfg,
	input  lbdp_pkg::state_t                     state,
	input  logic [lbdp_pkg::SAMPLE_W-1:0]        adc_sample,
	input  logic [lbdp_pkg::TIME_W-1:0]          now_ms,
	output lbdp_pkg::state_t                     state_next
);
	import lbdp_pkg::*;

	btn_t              raw;
	btn_t              stable_n;
	logic [TIME_W-1:0] target_diff;
	logic [TIME_W-1:0] hold_diff;
	logic [1:0]        k;

	always_comb begin
		if (adc_sample < cfg.lvl_main) begin
			raw = BTN_MAIN;
		end else if (adc_sample < cfg.lvl_cancel) begin
			raw = BTN_CANCEL;
		end else if (adc_sample < cfg.lvl_resume) begin
			raw = BTN_RES;
		end else if (adc_sample < cfg.open_min) begin
			raw = BTN_SET;
		end else begin
			raw = BTN_NONE;
		end
	end

	assign target_diff = now_ms - state.cand_target;
	assign hold_diff   = now_ms - state.deadline;
	assign k           = 2'(stable_n - 3'd1);

	always_comb begin
		state_next = state;
		stable_n   = state.stable;
		if (raw != state.cand) begin
			state_next.cand        = raw;
			state_next.cand_target = now_ms + TIME_W'(DEBOUNCE_TIME_MS);
		end else if (state.stable != state.cand && !target_diff[TIME_W-1]) begin
			stable_n = state.cand;
		end
		state_next.stable = stable_n;

		if (stable_n == BTN_NONE) begin
			if (state.driving != BTN_NONE && !hold_diff[TIME_W-1]) begin
				state_next.drive_bits = '0;
				state_next.driving    = BTN_NONE;
			end
		end else if (stable_n != state.driving) begin
			state_next.drive_bits = state.drive_bits | (MASK_W'(1) << k);
			state_next.driving    = stable_n;
			state_next.deadline   = now_ms + TIME_W'(cfg.pulse_ms[k]);
		end
	end

endmodule

// ----- tb/tb_ladder_button_debounce_pulse.sv -----
`timescale 1ns / 1ps

module tb_ladder_button_debounce_pulse;
	import lbdp_pkg::*;

	localparam int unsigned DEB_TIME_MS = 50;
	localparam int unsigned N_DIR = 24;

	typedef struct {
		logic [MASK_W-1:0] mask;
		btn_t              btn;
	} drive_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] smp;
		logic [TIME_W-1:0]   now;
		bit                  chk;
		logic [MASK_W-1:0]   mask;
		btn_t                btn;
	} dir_row_t;

	// Directed sequence, run with the register values loaded by reset.
	localparam dir_row_t DIR_ROWS [N_DIR] = '{
		'{12'd4095, 32'd0,         1'b1, 4'd0,  BTN_NONE},
		'{12'd0,    32'd10,        1'b1, 4'd0,  BTN_NONE},
		'{12'd499,  32'd59,        1'b1, 4'd0,  BTN_NONE},
		'{12'd0,    32'd60,        1'b1, 4'd1,  BTN_MAIN},
		'{12'd4095, 32'd70,        1'b1, 4'd1,  BTN_MAIN},
		'{12'd3500, 32'd120,       1'b1, 4'd1,  BTN_NONE},
		'{12'd4000, 32'd259,       1'b1, 4'd1,  BTN_NONE},
		'{12'd4000, 32'd260,       1'b1, 4'd0,  BTN_NONE},
		'{12'd500,  32'd300,       1'b0, 4'd0,  BTN_NONE},
		'{12'd1499, 32'd350,       1'b0, 4'd0,  BTN_NONE},
		'{12'd3499, 32'd360,       1'b0, 4'd0,  BTN_NONE},
		'{12'd3499, 32'd410,       1'b0, 4'd0,  BTN_NONE},
		'{12'd1500, 32'd420,       1'b0, 4'd0,  BTN_NONE},
		'{12'd2499, 32'd470,       1'b0, 4'd0,  BTN_NONE},
		'{12'd4095, 32'd480,       1'b0, 4'd0,  BTN_NONE},
		'{12'd4095, 32'd530,       1'b0, 4'd0,  BTN_NONE},
		'{12'd2000, 32'd540,       1'b0, 4'd0,  BTN_NONE},
		'{12'd2000, 32'd590,       1'b0, 4'd0,  BTN_NONE},
		'{12'd2500, 32'd600,       1'b0, 4'd0,  BTN_NONE},
		'{12'd4095, 32'hFFFF_FFF0, 1'b1, 4'd14, BTN_RES},
		'{12'd4095, 32'h0000_0022, 1'b1, 4'd14, BTN_NONE},
		'{12'd4095, 32'h8000_029E, 1'b1, 4'd14, BTN_NONE},
		'{12'd4095, 32'h8000_029D, 1'b1, 4'd0,  BTN_NONE},
		'{12'd1000, 32'hFFFF_FFFF, 1'b1, 4'd0,  BTN_NONE}
	};

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   cfg_we;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	logic [SAMPLE_W-1:0] bnd_main_cancel, bnd_cancel_res, bnd_res_set, bnd_open_min;
	logic [PULSE_W-1:0]  pulse_ms [4];

	btn_t              cand_btn, stable_btn, drive_btn;
	logic [TIME_W-1:0] cand_since, hold_until;
	logic [MASK_W-1:0] drive_mask;

	drive_t            drive_q [$];
	logic [TIME_W-1:0] clock_ms;
	int                src_idle_pct, rcv_idle_pct;
	int                fails, n_sent, n_checked, n_presses, n_clears, n_settings;

	ladder_button_debounce_pulse #(
		.DEBOUNCE_TIME_MS(DEB_TIME_MS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("[ladder_button_debounce_pulse] ERROR");
		$finish;
	end

	function automatic btn_t classify_level(input logic [SAMPLE_W-1:0] smp);
		if (smp < bnd_main_cancel) return BTN_MAIN;
		if (smp < bnd_cancel_res) return BTN_CANCEL;
		if (smp < bnd_res_set) return BTN_RES;
		if (smp < bnd_open_min) return BTN_SET;
		return BTN_NONE;
	endfunction

	// Wrap-safe: t counts as reached when now - t is not negative as a signed word.
	function automatic bit time_reached(input logic [TIME_W-1:0] now, input logic [TIME_W-1:0] t);
		logic [TIME_W-1:0] d;
		d = now - t;
		return ~d[TIME_W-1];
	endfunction

	function automatic void debounce_step(input logic [SAMPLE_W-1:0] smp,
			input logic [TIME_W-1:0] now, output drive_t res);
		btn_t       raw;
		logic [1:0] k;
		raw = classify_level(smp);
		if (raw != cand_btn) begin
			cand_btn = raw;
			cand_since = now;
		end else if (stable_btn != cand_btn &&
				time_reached(now, cand_since + TIME_W'(DEB_TIME_MS))) begin
			stable_btn = cand_btn;
		end
		if (stable_btn == BTN_NONE) begin
			if (drive_btn != BTN_NONE && time_reached(now, hold_until)) begin
				drive_mask = '0;
				drive_btn = BTN_NONE;
				n_clears++;
			end
		end else if (stable_btn != drive_btn) begin
			k = 2'(stable_btn - 1);
			drive_mask[k] = 1'b1;
			drive_btn = stable_btn;
			hold_until = now + TIME_W'(pulse_ms[k]);
			n_presses++;
		end
		res.mask = drive_mask;
		res.btn = stable_btn;
	endfunction

	task automatic send_item(input logic [SAMPLE_W-1:0] smp, input logic [TIME_W-1:0] now,
			input bit chk, input logic [MASK_W-1:0] mask, input btn_t btn);
		drive_t res;
		while ($urandom_range(0, 99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {4'd0, now, smp};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		debounce_step(smp, now, res);
		if (chk) begin
			res.mask = mask;
			res.btn = btn;
		end
		drive_q.push_back(res);
		n_sent++;
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		while (drive_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_LVL_MAIN:          bnd_main_cancel = val[SAMPLE_W-1:0];
			REG_LVL_CANCEL:        bnd_cancel_res = val[SAMPLE_W-1:0];
			REG_LVL_RESUME:        bnd_res_set = val[SAMPLE_W-1:0];
			REG_OPEN_MIN:          bnd_open_min = val[SAMPLE_W-1:0];
			REG_PULSE_MAIN_MS:     pulse_ms[0] = val;
			REG_PULSE_CANCEL_MS:   pulse_ms[1] = val;
			REG_PULSE_RES_MS:      pulse_ms[2] = val;
			REG_PULSE_SET_MS:      pulse_ms[3] = val;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic apply_setting(input logic [15:0] b0, input logic [15:0] b1,
			input logic [15:0] b2, input logic [15:0] b3, input logic [15:0] p0,
			input logic [15:0] p1, input logic [15:0] p2, input logic [15:0] p3);
		write_reg(REG_LVL_MAIN, b0);
		write_reg(REG_LVL_CANCEL, b1);
		write_reg(REG_LVL_RESUME, b2);
		write_reg(REG_OPEN_MIN, b3);
		write_reg(REG_PULSE_MAIN_MS, p0);
		write_reg(REG_PULSE_CANCEL_MS, p1);
		write_reg(REG_PULSE_RES_MS, p2);
		write_reg(REG_PULSE_SET_MS, p3);
		cfg_we <= 1'b0;
		n_settings++;
	endtask

	// Button presses are held levels with time running forward, with some glitches,
	// stray samples and large time jumps mixed in.
	task automatic run_presses(input int n_items);
		logic [SAMPLE_W-1:0] level, smp;
		logic [TIME_W-1:0]   step;
		int                  hold, sent, pick;
		sent = 0;
		while (sent < n_items) begin
			pick = $urandom_range(0, 99);
			if (pick < 35) begin
				level = SAMPLE_W'($urandom_range(bnd_open_min, 4095));
			end else if (pick < 55) begin
				case ($urandom_range(0, 3))
					0: level = bnd_main_cancel;
					1: level = bnd_cancel_res;
					2: level = bnd_res_set;
					default: level = bnd_open_min;
				endcase
				level = level + SAMPLE_W'($urandom_range(0, 4)) - 12'd2;
			end else begin
				level = SAMPLE_W'($urandom_range(0, 4095));
			end
			hold = $urandom_range(1, 12);
			for (int i = 0; i < hold && sent < n_items; i++) begin
				if ($urandom_range(0, 99) < 3) step = $urandom;
				else step = $urandom_range(0, 25);
				clock_ms = clock_ms + step;
				pick = $urandom_range(0, 99);
				if (pick < 8) smp = SAMPLE_W'($urandom_range(0, 4095));
				else if (pick < 15) smp = level ^ SAMPLE_W'($urandom_range(0, 3));
				else smp = level;
				send_item(smp, clock_ms, 1'b0, 4'd0, BTN_NONE);
				sent++;
			end
		end
	endtask

	always @(posedge clk) begin
		drive_t res;
		if (arst_n && m_tvalid && m_tready) begin
			if (drive_q.size() == 0) begin
				$error("unexpected result: output_mask %0h, confirmed_button %0d",
					m_tdata[3:0], m_tdata[6:4]);
				fails++;
			end else begin
				res = drive_q.pop_front();
				n_checked++;
				if (m_tdata[3:0] !== res.mask) begin
					$error("output_mask: expected %0h, got %0h", res.mask, m_tdata[3:0]);
					fails++;
				end
				if (m_tdata[6:4] !== res.btn) begin
					$error("confirmed_button: expected %0d, got %0d", res.btn, m_tdata[6:4]);
					fails++;
				end
			end
		end
		m_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
	end

	initial begin
		logic [15:0] a, b, c, d;
		fails = 0;
		n_sent = 0;
		n_checked = 0;
		n_presses = 0;
		n_clears = 0;
		n_settings = 0;
		src_idle_pct = 32;
		rcv_idle_pct = 73;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		m_tready <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_LVL_MAIN;
		cfg_data <= '0;
		bnd_main_cancel = RST_LVL_MAIN;
		bnd_cancel_res = RST_LVL_CANCEL;
		bnd_res_set = RST_LVL_RESUME;
		bnd_open_min = RST_OPEN_MIN;
		for (int i = 0; i < 4; i++) pulse_ms[i] = RST_PULSE_MS;
		cand_btn = BTN_NONE;
		stable_btn = BTN_NONE;
		drive_btn = BTN_NONE;
		cand_since = '0;
		hold_until = '0;
		drive_mask = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_DIR; i++) begin
			send_item(DIR_ROWS[i].smp, DIR_ROWS[i].now, DIR_ROWS[i].chk,
				DIR_ROWS[i].mask, DIR_ROWS[i].btn);
		end
		settle();

		clock_ms = 32'hFFFF_FE00;
		for (int ph = 0; ph < 6; ph++) begin
			case (ph / 2)
				0: begin
					src_idle_pct = 32;
					rcv_idle_pct = 73;
				end
				1: begin
					src_idle_pct = 73;
					rcv_idle_pct = 32;
				end
				default: begin
					src_idle_pct = 0;
					rcv_idle_pct = 0;
				end
			endcase
			case (ph)
				0: begin
					a = 16'($urandom_range(0, 1023));
					b = a + 16'($urandom_range(0, 1023));
					c = b + 16'($urandom_range(0, 1023));
					d = c + 16'($urandom_range(0, 1023));
					apply_setting({4'($urandom), a[11:0]}, b, c, {4'($urandom), d[11:0]},
						16'($urandom_range(0, 300)), 16'($urandom_range(0, 300)),
						16'($urandom_range(0, 300)), 16'($urandom_range(0, 300)));
				end
				1: apply_setting(16'd0, 16'd0, 16'd0, 16'd4095, 16'd0, 16'd0, 16'd0, 16'd0);
				2: apply_setting(16'hFFFF, 16'd4095, 16'd4095, 16'd4095,
					16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
				3: apply_setting(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
					16'($urandom_range(0, 400)), 16'($urandom_range(0, 400)),
					16'($urandom_range(0, 400)), 16'($urandom_range(0, 400)));
				4: begin
					a = 16'($urandom_range(0, 1023));
					b = a + 16'($urandom_range(0, 1023));
					c = b + 16'($urandom_range(0, 1023));
					d = c + 16'($urandom_range(0, 1023));
					apply_setting(a, {4'($urandom), b[11:0]}, {4'($urandom), c[11:0]}, d,
						16'd0, 16'hFFFF, 16'($urandom_range(0, 300)),
						16'($urandom_range(0, 300)));
				end
				default: apply_setting(16'(RST_LVL_MAIN), 16'(RST_LVL_CANCEL),
					16'(RST_LVL_RESUME), 16'(RST_OPEN_MIN),
					RST_PULSE_MS, RST_PULSE_MS, RST_PULSE_MS, RST_PULSE_MS);
			endcase
			run_presses(115);
			settle();
		end

		$display("Run covered %0d sample transfers and %0d checked results under %0d settings.",
			n_sent, n_checked, n_settings + 1);
		$display("The predictor saw %0d button confirmations and %0d clears of the drive bits.",
			n_presses, n_clears);
		if (fails == 0 && drive_q.size() == 0) begin
			$display("[ladder_button_debounce_pulse] OK");
		end else begin
			$display("[ladder_button_debounce_pulse] ERROR");
		end
		$finish;
	end

endmodule
